// ===== sv/color_prewitt_max_channel_gradient_unit_assert.svh =====
// Assertion macros for the color Prewitt gradient unit.
`ifndef COLOR_PREWITT_MAX_CHANNEL_GRADIENT_UNIT_ASSERT_SVH
`define COLOR_PREWITT_MAX_CHANNEL_GRADIENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CPMG_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpmg assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CPMG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpmg assertion failed");

`endif

// ===== sv/cpmg_pkg.sv =====
// Shared types and constants of the color Prewitt gradient unit.
`default_nettype none
package cpmg_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT     = 2048;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 1;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 3;
    localparam int PIX_W          = CH_W * NUM_CH;
    localparam int GRAD_W         = 10;
    localparam int COORD_W        = 11;
    localparam int ROW_W          = 11;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] MIN_SIZE     = CFG_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    // One window column, index 0 is the top row.
    typedef pix_t [2:0] win_col_t;

    // Raster position of one pixel, resolved at accept time.
    typedef struct packed {
        logic               has_res;
        logic               last;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
    } pos_t;

endpackage
`default_nettype wire

// ===== sv/cpmg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpmg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/cpmg_raster.sv =====
// Size registers and raster column and row counters.
`default_nettype none
module cpmg_raster import cpmg_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_wdata,
    input  wire logic                         advance,
    output logic      [$clog2(MAX_WIDTH)-1:0] col_idx,
    output pos_t                              pos
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] w_eff, col_wide, col_inc, col_dec;
    logic [CFG_W-1:0] h_eff, row_inc;
    logic             wrap_col, wrap_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                endcase
            end
            if (advance) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_comb begin
        // clamp the sizes
        w_eff = CMP_W'(width_reg);
        if (width_reg < MIN_SIZE) begin
            w_eff = CMP_W'(MIN_SIZE);
        end else if (w_eff > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg < MIN_SIZE) begin
            h_eff = MIN_SIZE;
        end else if (height_reg > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end

        col_wide = CMP_W'(col_reg);
        col_inc  = col_wide + CMP_W'(1);
        col_dec  = col_wide - CMP_W'(1);
        row_inc  = CFG_W'(row_reg) + CFG_W'(1);
        wrap_col = (col_inc >= w_eff);
        wrap_row = (row_inc >= h_eff);

        if (wrap_col) begin
            col_next = '0;
            row_next = wrap_row ? '0 : row_inc[ROW_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end

        pos.has_res = (row_reg >= ROW_W'(2)) && (col_wide >= CMP_W'(2));
        pos.last    = wrap_col && wrap_row;
        pos.out_col = col_dec[COORD_W-1:0];
        pos.out_row = row_reg - ROW_W'(1);
    end

    assign col_idx = col_reg;

endmodule
`default_nettype wire

// ===== sv/cpmg_grad.sv =====
// Prewitt responses of a 3x3 window, largest absolute value over channels.
`default_nettype none
module cpmg_grad import cpmg_pkg::*; (
    input  wire win_col_t     left_col,
    input  wire win_col_t     mid_col,
    input  wire win_col_t     right_col,
    output logic [GRAD_W-1:0] grad_x,
    output logic [GRAD_W-1:0] grad_y
);

    logic [GRAD_W-1:0] sum_r  [NUM_CH];
    logic [GRAD_W-1:0] sum_l  [NUM_CH];
    logic [GRAD_W-1:0] sum_bt [NUM_CH];
    logic [GRAD_W-1:0] sum_tp [NUM_CH];
    logic [GRAD_W-1:0] abs_x  [NUM_CH];
    logic [GRAD_W-1:0] abs_y  [NUM_CH];

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_r[ch]  = GRAD_W'(right_col[0][ch*CH_W +: CH_W])
                       + GRAD_W'(right_col[1][ch*CH_W +: CH_W])
                       + GRAD_W'(right_col[2][ch*CH_W +: CH_W]);
            sum_l[ch]  = GRAD_W'(left_col[0][ch*CH_W +: CH_W])
                       + GRAD_W'(left_col[1][ch*CH_W +: CH_W])
                       + GRAD_W'(left_col[2][ch*CH_W +: CH_W]);
            sum_bt[ch] = GRAD_W'(left_col[2][ch*CH_W +: CH_W])
                       + GRAD_W'(mid_col[2][ch*CH_W +: CH_W])
                       + GRAD_W'(right_col[2][ch*CH_W +: CH_W]);
            sum_tp[ch] = GRAD_W'(left_col[0][ch*CH_W +: CH_W])
                       + GRAD_W'(mid_col[0][ch*CH_W +: CH_W])
                       + GRAD_W'(right_col[0][ch*CH_W +: CH_W]);
            // absolute difference of two unsigned sums
            abs_x[ch] = (sum_r[ch] >= sum_l[ch]) ? sum_r[ch] - sum_l[ch]
                                                 : sum_l[ch] - sum_r[ch];
            abs_y[ch] = (sum_bt[ch] >= sum_tp[ch]) ? sum_bt[ch] - sum_tp[ch]
                                                   : sum_tp[ch] - sum_bt[ch];
        end
        grad_x = abs_x[0];
        grad_y = abs_y[0];
        for (int ch = 1; ch < NUM_CH; ch++) begin
            if (abs_x[ch] > grad_x) begin
                grad_x = abs_x[ch];
            end
            if (abs_y[ch] > grad_y) begin
                grad_y = abs_y[ch];
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/color_prewitt_max_channel_gradient_unit.sv =====
// Top level of the color Prewitt gradient unit: line stores, window, result register.
//
//   channel   dir  handshake          payload
//   s_        in   s_valid/s_ready    s_blue, s_green, s_red (one BGR pixel, raster order)
//   m_        out  m_valid/m_ready    m_grad_x, m_grad_y, m_center_col, m_center_row,
//                                     m_frame_done
//   cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (image_width, image_height)
//
// Takes one pixel beat per clock while the read stage can pass its pixel on. The line
// stores are read and the pixel is registered at the accept edge; the window and
// gradient logic feed the result register as the pixel leaves the read stage.
// Reset sets the size registers to 640 x 480 and clears the raster counters and the
// valid flags; line store contents are not cleared and need no clearing pass.
// A stalled result beat holds only pixels that produce a result; the rest drain.
`default_nettype none
module color_prewitt_max_channel_gradient_unit import cpmg_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CH_W-1:0]      s_blue,
    input  wire logic [CH_W-1:0]      s_green,
    input  wire logic [CH_W-1:0]      s_red,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [GRAD_W-1:0]    m_grad_x,
    output logic      [GRAD_W-1:0]    m_grad_y,
    output logic      [COORD_W-1:0]   m_center_col,
    output logic      [COORD_W-1:0]   m_center_row,
    output logic                      m_frame_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // input beat and current raster position
    logic             s_acc;
    logic [COL_W-1:0] col_idx;
    pos_t             pos;

    // read stage: pixel waits here while the line stores are read
    logic             s1_vld_reg, s1_vld_next;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    pos_t             s1_pos_reg;
    logic             s1_adv;

    // line store read data: previous row and the row before it
    pix_t             line_a_rd, line_b_rd;
    win_col_t         new_col;

    // window: left and middle columns; the right column is new_col
    win_col_t         win0_reg, win1_reg;

    logic [GRAD_W-1:0] grad_x, grad_y;

    logic              m_valid_reg, m_valid_next;
    logic [GRAD_W-1:0] grad_x_reg, grad_y_reg;
    logic [COORD_W-1:0] col_out_reg, row_out_reg;
    logic              done_reg;
    logic              out_free;

    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    // advance a pixel without a result at once; one with a result needs a free slot
    assign s1_adv   = s1_vld_reg && (out_free || !s1_pos_reg.has_res);
    assign s_ready  = !s1_vld_reg || s1_adv;

    cpmg_raster #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_raster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (s_acc),
        .col_idx   (col_idx),
        .pos       (pos)
    );

    // read at accept, write back as the pixel leaves the read stage; consecutive
    // pixels always sit in different columns, so the two addresses never collide
    cpmg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (s_acc),
        .rd_addr (col_idx),
        .rd_data (line_a_rd)
    );

    cpmg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (line_a_rd),
        .rd_en   (s_acc),
        .rd_addr (col_idx),
        .rd_data (line_b_rd)
    );

    assign new_col[0] = line_b_rd;
    assign new_col[1] = line_a_rd;
    assign new_col[2] = s1_pix_reg;

    cpmg_grad u_grad (
        .left_col  (win0_reg),
        .mid_col   (win1_reg),
        .right_col (new_col),
        .grad_x    (grad_x),
        .grad_y    (grad_y)
    );

    always_comb begin
        s1_vld_next = s1_vld_reg;
        if (s_acc) begin
            s1_vld_next = 1'b1;
        end else if (s1_adv) begin
            s1_vld_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv && s1_pos_reg.has_res) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            s1_vld_reg  <= s1_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pix_reg <= {s_red, s_green, s_blue};
            s1_col_reg <= col_idx;
            s1_pos_reg <= pos;
        end
        if (s1_adv) begin
            // shift the window left, bring in the new column
            win0_reg <= win1_reg;
            win1_reg <= new_col;
        end
        if (s1_adv && s1_pos_reg.has_res) begin
            grad_x_reg  <= grad_x;
            grad_y_reg  <= grad_y;
            col_out_reg <= s1_pos_reg.out_col;
            row_out_reg <= s1_pos_reg.out_row;
            done_reg    <= s1_pos_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_grad_x     = grad_x_reg;
    assign m_grad_y     = grad_y_reg;
    assign m_center_col = col_out_reg;
    assign m_center_row = row_out_reg;
    assign m_frame_done = done_reg;

`include "color_prewitt_max_channel_gradient_unit_assert.svh"

    // an empty read stage always takes a beat
    `CPMG_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !s1_vld_reg, s_ready)
    // write-back column never equals the column being read
    `CPMG_ASSERT_NOW(a_no_ram_collision, aclk, aresetn, s_acc && s1_adv,
                     s1_col_reg != col_idx)
    // the last pixel of an image is always an interior pixel
    `CPMG_ASSERT_NOW(a_last_has_result, aclk, aresetn, s_acc && pos.last, pos.has_res)
    // a result entering the output register raises valid next cycle
    `CPMG_ASSERT_NEXT(a_result_lands, aclk, aresetn, s1_adv && s1_pos_reg.has_res,
                      m_valid_reg && (m_center_row != '0) && (m_center_col != '0))

endmodule
`default_nettype wire

// ===== bench/color_prewitt_max_channel_gradient_unit_tb.sv =====
// Self-checking bench for the color Prewitt gradient unit: directed frames, extreme sizes, random images.
module color_prewitt_max_channel_gradient_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpmg_pkg::*;

    // Slowest correct run: about 1050 pixel beats, each behind the longest idle gap and
    // each result behind the longest receiver stall, plus one long hold and the phase
    // settles; the limit leaves several times that.
    localparam int unsigned RUN_LIMIT     = 200_000;
    // After the last expected result, wait SETTLE_CYCLES more to drain pixels that
    // produce no result before the size registers move.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned DRAIN_CYCLES  = 10;
    // One long receiver hold-off, started once this many results have gone by.
    localparam int unsigned HOLD_AFTER    = 60;
    localparam int unsigned HOLD_CYCLES   = 400;
    // Side of the square image that the hold-off falls in.
    localparam int unsigned HOLD_SIDE     = 16;
    localparam int unsigned RANDOM_ITEMS  = 770;
    // From here on neither side idles.
    localparam int unsigned CALM_FROM     = 650;

    // One result beat, field for field.
    typedef struct packed {
        logic [GRAD_W-1:0]  gx;
        logic [GRAD_W-1:0]  gy;
        logic [COORD_W-1:0] col;
        logic [ROW_W-1:0]   row;
        logic               done;
    } grad_res_t;

    // One directed pixel; want is used in place of the predictor where has_want is set.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            has_want;
        grad_res_t       want;
    } pattern_row_t;

    localparam grad_res_t NO_WANT = '0;

    // Three 3x3 frames at the smallest size (width 0 and height 1 both clamp to 3).
    // Frame one: dark left column, bright right column, so every channel gives the
    // full horizontal swing and no vertical one. Frame two: bright top row over a
    // dark bottom row, the full vertical swing. Frame three: mixed channels, so a
    // different channel wins in each direction; the predictor judges it.
    localparam pattern_row_t DIRECTED_PIXELS [27] = '{
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, '{10'd765, 10'd0, 11'd1, 11'd1, 1'b1}},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{8'h80, 8'h80, 8'h80, 1'b0, NO_WANT},
        '{8'h80, 8'h80, 8'h80, 1'b0, NO_WANT},
        '{8'h80, 8'h80, 8'h80, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'h00, 1'b1, '{10'd0, 10'd765, 11'd1, 11'd1, 1'b1}},
        '{8'hFF, 8'h00, 8'h01, 1'b0, NO_WANT},
        '{8'h80, 8'h7F, 8'hAA, 1'b0, NO_WANT},
        '{8'h00, 8'hFF, 8'h55, 1'b0, NO_WANT},
        '{8'h01, 8'hFE, 8'h00, 1'b0, NO_WANT},
        '{8'h55, 8'hAA, 8'hFF, 1'b0, NO_WANT},
        '{8'hFE, 8'h01, 8'h80, 1'b0, NO_WANT},
        '{8'h00, 8'h00, 8'hFF, 1'b0, NO_WANT},
        '{8'h7F, 8'h80, 8'h01, 1'b0, NO_WANT},
        '{8'hFF, 8'hFF, 8'h00, 1'b0, NO_WANT}
    };

    // Every input starts at a known value.
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    cfg_reg_t           cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [CH_W-1:0]    s_blue    = '0;
    logic [CH_W-1:0]    s_green   = '0;
    logic [CH_W-1:0]    s_red     = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [GRAD_W-1:0]  m_grad_x;
    logic [GRAD_W-1:0]  m_grad_y;
    logic [COORD_W-1:0] m_center_col;
    logic [COORD_W-1:0] m_center_row;
    logic               m_frame_done;

    // Predictor state: its own line stores, window, raster position and size registers.
    pix_t             row_above [MAX_WIDTH_DEF];
    pix_t             row_two_up [MAX_WIDTH_DEF];
    pix_t             win_cols [3][3];      // [column 0 left..2 right][row 0 top..2 bottom]
    int unsigned      next_col = 0;
    int unsigned      next_row = 0;
    logic [CFG_W-1:0] size_w   = WIDTH_RESET;
    logic [CFG_W-1:0] size_h   = HEIGHT_RESET;

    grad_res_t   pending_grads [$];
    int unsigned mismatches = 0;
    int unsigned grads_seen = 0;
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    bit          calm       = 1'b0;

    color_prewitt_max_channel_gradient_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_blue       (s_blue),
        .s_green      (s_green),
        .s_red        (s_red),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_grad_x     (m_grad_x),
        .m_grad_y     (m_grad_y),
        .m_center_col (m_center_col),
        .m_center_row (m_center_row),
        .m_frame_done (m_frame_done)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the raster by one pixel; return 1 with the gradients when the pixel
    // completes an interior window.
    function automatic bit predict_gradients(input pix_t px, output grad_res_t res);
        int unsigned wid, hgt, c, r, idx;
        int          sx, sy, max_x, max_y;
        int          k, j, ch;
        bit          hit;
        wid = clamp_size(size_w, MAX_WIDTH_DEF);
        hgt = clamp_size(size_h, MAX_HEIGHT);
        c   = next_col;
        r   = next_row;
        idx = c % MAX_WIDTH_DEF;
        res = '0;
        hit = 1'b0;
        // shift the window left, bring in the new column from both line stores
        for (k = 0; k < 2; k++)
            for (j = 0; j < 3; j++)
                win_cols[k][j] = win_cols[k+1][j];
        win_cols[2][0]  = row_two_up[idx];
        win_cols[2][1]  = row_above[idx];
        win_cols[2][2]  = px;
        row_two_up[idx] = row_above[idx];
        row_above[idx]  = px;
        if (r >= 2 && c >= 2) begin
            max_x = 0;
            max_y = 0;
            for (ch = 0; ch < NUM_CH; ch++) begin
                sx = 0;
                sy = 0;
                for (k = 0; k < 3; k++) begin
                    sx += int'(win_cols[2][k][ch*CH_W +: CH_W])
                        - int'(win_cols[0][k][ch*CH_W +: CH_W]);
                    sy += int'(win_cols[k][2][ch*CH_W +: CH_W])
                        - int'(win_cols[k][0][ch*CH_W +: CH_W]);
                end
                if (sx < 0) sx = -sx;
                if (sy < 0) sy = -sy;
                if (sx > max_x) max_x = sx;
                if (sy > max_y) max_y = sy;
            end
            res.gx   = GRAD_W'(max_x);
            res.gy   = GRAD_W'(max_y);
            res.col  = COORD_W'(c - 1);
            res.row  = ROW_W'(r - 1);
            res.done = (r + 1 >= hgt) && (c + 1 >= wid);
            hit      = 1'b1;
        end
        // wrap on reaching or passing the last column / row
        if (c + 1 >= wid) begin
            next_col = 0;
            next_row = (r + 1 >= hgt) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
        return hit;
    endfunction

    // Bias each channel toward its extremes so saturated gradients come up often.
    function automatic pix_t random_pixel();
        pix_t px;
        int   ch;
        px = '0;
        for (ch = 0; ch < NUM_CH; ch++) begin
            case ($urandom_range(0, 9))
                0:       px[ch*CH_W +: CH_W] = '0;
                1:       px[ch*CH_W +: CH_W] = '1;
                default: px[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    // Offer one pixel beat, maybe after an idle burst; hold it until accepted, then
    // record what it should produce.
    task automatic offer_pixel(input pix_t px, input bit typed, input grad_res_t want);
        grad_res_t pred;
        bit        hit;
        if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_blue  <= px[CH_W-1:0];
        s_green <= px[2*CH_W-1:CH_W];
        s_red   <= px[3*CH_W-1:2*CH_W];
        do @(posedge aclk); while (s_ready !== 1'b1);
        hit = predict_gradients(px, pred);
        if (typed)
            pending_grads.push_back(want);
        else if (hit)
            pending_grads.push_back(pred);
    endtask

    // Write the size registers on consecutive edges, then drop the enable.
    task automatic write_sizes(input logic [CFG_W-1:0] wid, input logic [CFG_W-1:0] hgt,
                               input bit do_w, input bit do_h);
        if (do_w) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_IMAGE_WIDTH;
            cfg_wdata <= wid;
            @(posedge aclk);
            size_w = wid;
        end
        if (do_h) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_IMAGE_HEIGHT;
            cfg_wdata <= hgt;
            @(posedge aclk);
            size_h = hgt;
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let pixels with no result drain.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_grads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    initial begin : stimulus
        int unsigned      sent, n, i;
        logic [CFG_W-1:0] w, h;
        bit               do_w, do_h;
        win_cols = '{default: '0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames at the smallest size, reached through out-of-range values.
        gap_pct   = 20;
        stall_pct = 20;
        write_sizes(CFG_W'(0), CFG_W'(1), 1'b1, 1'b1);
        for (i = 0; i < $size(DIRECTED_PIXELS); i++)
            offer_pixel({DIRECTED_PIXELS[i].red, DIRECTED_PIXELS[i].green,
                         DIRECTED_PIXELS[i].blue},
                        DIRECTED_PIXELS[i].has_want, DIRECTED_PIXELS[i].want);

        // One whole square image with light idling. The long receiver hold-off falls
        // in here while pixels keep coming, so the block fills and pushes back.
        settle();
        gap_pct   = 10;
        stall_pct = 5;
        write_sizes(CFG_W'(HOLD_SIDE), CFG_W'(HOLD_SIDE), 1'b1, 1'b1);
        repeat (HOLD_SIDE * HOLD_SIDE) offer_pixel(random_pixel(), 1'b0, NO_WANT);

        // Random phases: mostly small images so frames complete often, now and then
        // out-of-range or large sizes. Sizes move mid-image as well.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 19))
                0, 1:    w = CFG_W'($urandom_range(0, 2));
                2, 3, 4: w = CFG_W'($urandom_range(11, 64));
                5:       w = CFG_W'($urandom_range(2049, 4095));
                default: w = CFG_W'($urandom_range(3, 10));
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:    h = CFG_W'($urandom_range(0, 2));
                3, 4, 5, 6: h = CFG_W'($urandom_range(9, 40));
                7:          h = CFG_W'($urandom_range(41, 4095));
                default:    h = CFG_W'($urandom_range(3, 8));
            endcase
            do_w = $urandom_range(0, 3) != 0;
            do_h = $urandom_range(0, 3) != 0;
            // widen only at the start of an image, so every line store entry that a
            // window reads has been written by the rows above it
            if (do_w && clamp_size(w, MAX_WIDTH_DEF) > clamp_size(size_w, MAX_WIDTH_DEF)
                    && (next_col != 0 || next_row != 0))
                do_w = 1'b0;
            write_sizes(w, h, do_w, do_h);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 8;
                default: gap_pct = 25;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 8;
                default: stall_pct = 25;
            endcase
            n = $urandom_range(20, 120);
            for (i = 0; i < n && sent < RANDOM_ITEMS; i++) begin
                offer_pixel(random_pixel(), 1'b0, NO_WANT);
                sent++;
                if (sent >= CALM_FROM)
                    calm = 1'b1;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("color_prewitt_max_channel_gradient_unit_tb passed");
        else
            $display("color_prewitt_max_channel_gradient_unit_tb failed");
        $finish;
    end

    // Receiver: ready by default, stall in random bursts, and once hold off long
    // enough for the block to fill and push back on its input.
    initial begin : result_sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && grads_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Match each result beat against the oldest expectation.
    always @(posedge aclk) begin : grad_checker
        grad_res_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            grads_seen++;
            if (pending_grads.size() == 0) begin
                mismatches++;
                $display("%0t result beat with none expected: expected none, got col %0d row %0d",
                         $time, m_center_col, m_center_row);
            end else begin
                want = pending_grads.pop_front();
                check_field("grad_x", 16'(want.gx), 16'(m_grad_x));
                check_field("grad_y", 16'(want.gy), 16'(m_grad_y));
                check_field("center_col", 16'(want.col), 16'(m_center_col));
                check_field("center_row", 16'(want.row), 16'(m_center_row));
                check_field("frame_done", 16'(want.done), 16'(m_frame_done));
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("color_prewitt_max_channel_gradient_unit_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/cpmg_pkg.sv
sv/cpmg_ram.sv
sv/cpmg_raster.sv
sv/cpmg_grad.sv
sv/color_prewitt_max_channel_gradient_unit.sv
bench/color_prewitt_max_channel_gradient_unit_tb.sv
